// ===== hw/rtl/lpvd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpvd_pkg: shared definitions for the length-prefixed varint triple decoder
// Value width, varint constants and result status codes.
// ----------------------------------------------------------------------------
package lpvd_pkg;

  // width kept for each decoded value
  localparam int VALUE_BITS = 32;

  // varint byte layout
  localparam logic [7:0] CONT_MASK = 8'h80;
  localparam logic [7:0] DATA_MASK = 8'h7f;
  localparam int         GROUP_BITS = 7;

  // tenth byte of a varint may only carry the top bit of a 64-bit value
  localparam logic [3:0] LAST_POS      = 4'd9;
  localparam logic [7:0] LAST_BYTE_MAX = 8'd1;

  // values per frame
  localparam logic [1:0] NUM_FIELDS = 2'd3;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_MALFORMED = 2'd1;
  localparam status_t ST_TRUNCATED = 2'd2;

  typedef logic [VALUE_BITS-1:0] value_t;

endpackage

// ===== hw/rtl/length_prefixed_varint_triple_decoder.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_varint_triple_decoder
// Decodes framed streams of three unsigned base-128 varints per frame.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. A frame is a two-byte big-endian length and then
// that many payload bytes holding velocity, rpm and fuel as unsigned
// base-128 varints, each kept as its low 32 bits. One result per frame is
// presented on the output register in the cycle after the frame's last byte
// (the length low byte for an empty frame); status 1 marks an overlong
// varint, status 2 a frame that ended before three values. Every byte passes
// through the decode logic; the input stalls only when a byte would finish a
// frame while the previous result is still held on a stalled output.
// ----------------------------------------------------------------------------
module length_prefixed_varint_triple_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lpvd_pkg::VALUE_BITS-1:0]     velocity,
  output logic [lpvd_pkg::VALUE_BITS-1:0]     rpm,
  output logic [lpvd_pkg::VALUE_BITS-1:0]     fuel,
  output lpvd_pkg::status_t                   status
);

  localparam logic [1:0] PH_LEN_HI  = 2'd0;
  localparam logic [1:0] PH_LEN_LO  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  // frame state
  logic [1:0]        phase, phase_next;
  logic [15:0]       bytes_left, bytes_left_next;
  logic [1:0]        field_number, field_number_next;
  lpvd_pkg::value_t  accumulator, accumulator_next;
  logic [3:0]        byte_position, byte_position_next;
  lpvd_pkg::value_t  first_value, first_value_next;
  lpvd_pkg::value_t  second_value, second_value_next;
  lpvd_pkg::value_t  third_value, third_value_next;
  logic              malformed, malformed_next;

  logic              accept;
  logic              frame_end;
  logic [6:0]        shift_amt;
  logic [63:0]       shifted;
  lpvd_pkg::value_t  acc_merged;
  logic [15:0]       len_full;
  logic [15:0]       left_dec;
  lpvd_pkg::status_t status_next;

  // placed group of the current byte
  assign shift_amt  = 7'(byte_position) * 7'(lpvd_pkg::GROUP_BITS);
  assign shifted    = {56'd0, data_byte & lpvd_pkg::DATA_MASK} << shift_amt[5:0];
  assign acc_merged = accumulator | shifted[lpvd_pkg::VALUE_BITS-1:0];
  assign len_full   = {bytes_left[15:8], data_byte};
  assign left_dec   = bytes_left - 16'd1;

  // per-byte decode
  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    field_number_next  = field_number;
    accumulator_next   = accumulator;
    byte_position_next = byte_position;
    first_value_next   = first_value;
    second_value_next  = second_value;
    third_value_next   = third_value;
    malformed_next     = malformed;
    frame_end          = 1'b0;
    unique case (phase)
      PH_LEN_LO: begin
        bytes_left_next = len_full;
        phase_next      = PH_PAYLOAD;
        frame_end       = (len_full == 16'd0);
      end
      PH_PAYLOAD: begin
        if (!malformed && field_number < lpvd_pkg::NUM_FIELDS) begin
          if (byte_position >= lpvd_pkg::LAST_POS && data_byte > lpvd_pkg::LAST_BYTE_MAX) begin
            malformed_next = 1'b1;
          end else if ((data_byte & lpvd_pkg::CONT_MASK) != 8'd0) begin
            accumulator_next   = acc_merged;
            byte_position_next = byte_position + 4'd1;
          end else begin
            unique case (field_number)
              2'd0:    first_value_next  = acc_merged;
              2'd1:    second_value_next = acc_merged;
              default: third_value_next  = acc_merged;
            endcase
            field_number_next  = field_number + 2'd1;
            accumulator_next   = '0;
            byte_position_next = 4'd0;
          end
        end
        bytes_left_next = left_dec;
        frame_end       = (left_dec == 16'd0);
      end
      default: begin
        bytes_left_next = {data_byte, 8'd0};
        phase_next      = PH_LEN_LO;
      end
    endcase
  end

  // status of a finishing frame
  always_comb begin
    priority if (malformed_next) begin
      status_next = lpvd_pkg::ST_MALFORMED;
    end else if (field_number_next < lpvd_pkg::NUM_FIELDS) begin
      status_next = lpvd_pkg::ST_TRUNCATED;
    end else begin
      status_next = lpvd_pkg::ST_OK;
    end
  end

  // hold off only a frame-ending byte while the result register is blocked
  assign in_stall = out_valid && out_stall && frame_end;
  assign accept   = in_valid && !in_stall;

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst || (accept && frame_end)) begin
      phase         <= PH_LEN_HI;
      bytes_left    <= '0;
      field_number  <= '0;
      accumulator   <= '0;
      byte_position <= '0;
      first_value   <= '0;
      second_value  <= '0;
      third_value   <= '0;
      malformed     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      field_number  <= field_number_next;
      accumulator   <= accumulator_next;
      byte_position <= byte_position_next;
      first_value   <= first_value_next;
      second_value  <= second_value_next;
      third_value   <= third_value_next;
      malformed     <= malformed_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && frame_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      velocity <= first_value_next;
      rpm      <= second_value_next;
      fuel     <= third_value_next;
      status   <= status_next;
    end
  end

endmodule
